@@ rtl/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic promote;  // request hit: cells up to the hit shift down one
		logic insert;   // put miss with nonzero capacity: whole chain shifts down one
	} cell_ctl_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
`timescale 1ns / 1ps

// LRU key/value cache, fully associative.
//
// Request channel: a request (mode, key, write_value) is taken at a rising
// edge with start high and busy low. busy is never raised, so a request can
// be issued every cycle. mode 0 is a get, mode 1 a put.
// Result channel: done pulses for one cycle with found and read_value. The
// taking edge registers the request; the next edge registers the compare,
// the chain update and the result. One result per request, in request order.
// The receiver cannot stall; results must be taken when done is high.
// Throughput is one request per cycle: the key compare is combinational, and
// the cell chain shifts at the same edge that registers the result.
// Config channel: cfg_valid/cfg_ready writes the 5-bit capacity. cfg_ready is
// always high. Write only while no request is in flight.
// Storage: a chain of cells ordered by recency, cell 0 most recent. A hit
// rotates the hit entry to the head; an insert shifts the whole chain and
// drops the last held entry when the count has reached capacity.
// Reset (arst_n low) empties the cache and sets capacity to 16. No clearing
// pass is needed; the asynchronous reset clears every valid bit.

module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              mode,
	input  logic signed [lkv_pkg::DATA_W-1:0] key,
	input  logic signed [lkv_pkg::DATA_W-1:0] write_value,
	output logic                              done,
	output logic                              found,
	output logic signed [lkv_pkg::DATA_W-1:0] read_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0]         cfg_data
);
	import lkv_pkg::*;

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	// config
	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    cap_eff;

	// request stage
	logic                     req_valid_s1;
	logic                     mode_s1;
	logic signed [DATA_W-1:0] key_s1;
	logic signed [DATA_W-1:0] wval_s1;

	// chain
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            new_count;
	cell_ctl_t                ctl;
	entry_t                   head;
	entry_t                   cell_entry [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]   match_vec;
	logic [MAX_ENTRIES-1:0]   valid_vec;
	logic [MAX_ENTRIES-1:0]   ins_valid;
	logic [MAX_ENTRIES-1:0]   therm_vec;
	logic [MAX_ENTRIES:0]     seen;
	logic [DATA_W-1:0]        hv [MAX_ENTRIES+1];
	logic                     hit;

	// result
	logic                     done_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] read_value_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// capacity above the table size acts as the table size
	assign cap_eff = (CMPW'(capacity_q) > CMPW'(MAX_ENTRIES)) ?
		CW'(MAX_ENTRIES) : CW'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode;
			key_s1  <= key;
			wval_s1 <= write_value;
		end
	end

	assign hit = seen[MAX_ENTRIES];

	assign ctl.promote = req_valid_s1 && hit;
	assign ctl.insert  = req_valid_s1 && !hit && (mode_s1 == MODE_PUT) &&
		(cap_eff != '0);

	// full: the least recent entry falls off, count holds
	assign new_count = (count_q >= cap_eff) ? count_q : count_q + CW'(1);

	// new head: the requested key, with the put value or the hit value kept
	assign head.valid = 1'b1;
	assign head.key   = key_s1;
	assign head.value = (mode_s1 == MODE_PUT) ? wval_s1 : $signed(hv[MAX_ENTRIES]);

	assign seen[0] = 1'b0;
	assign hv[0]   = '0;

	for (genvar p = 0; p < MAX_ENTRIES; p++) begin : g_cell
		entry_t prev;

		if (p == 0) begin : g_head
			assign prev = head;
		end else begin : g_link
			assign prev = cell_entry[p-1];
		end

		assign ins_valid[p] = CW'(p) < new_count;
		assign therm_vec[p] = CW'(p) < count_q;
		assign valid_vec[p] = cell_entry[p].valid;

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_key    (key_s1),
			.ins_valid  (ins_valid[p]),
			.prev_entry (prev),
			.seen_in    (seen[p]),
			.hv_in      (hv[p]),
			.entry      (cell_entry[p]),
			.match      (match_vec[p]),
			.seen_out   (seen[p+1]),
			.hv_out     (hv[p+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= req_valid_s1;
			if (ctl.insert) begin
				count_q <= new_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			found_q <= hit;
			if (mode_s1 == MODE_PUT) begin
				read_value_q <= '0;
			end else if (hit) begin
				read_value_q <= $signed(hv[MAX_ENTRIES]);
			end else begin
				read_value_q <= MISS_VALUE;
			end
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign read_value = read_value_q;

`ifndef SYNTHESIS
	// keys held in the chain are unique
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 |-> $onehot0(match_vec))
		else $error("more than one cell matched the key");

	// held entries are packed at the head of the chain
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec == therm_vec)
		else $error("cell valid bits disagree with entry count");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 |=> done)
		else $error("request without result");

	a_put_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid_s1 && mode_s1 == MODE_PUT) |=> (read_value == '0))
		else $error("put result not zero");
`endif

endmodule

@@ rtl/lkv_cell.sv @@
`timescale 1ns / 1ps

module lkv_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkv_pkg::cell_ctl_t            ctl,
	input  logic signed [lkv_pkg::DATA_W-1:0] cmp_key,
	input  logic                          ins_valid,
	input  lkv_pkg::entry_t               prev_entry,
	input  logic                          seen_in,
	input  logic [lkv_pkg::DATA_W-1:0]    hv_in,
	output lkv_pkg::entry_t               entry,
	output logic                          match,
	output logic                          seen_out,
	output logic [lkv_pkg::DATA_W-1:0]    hv_out
);
	import lkv_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     upd;

	assign match    = valid_q && (key_q == cmp_key);
	assign seen_out = seen_in | match;
	assign hv_out   = hv_in | (match ? DATA_W'(value_q) : '0);

	// on a hit, only cells at or above the hit position move
	assign upd = ctl.insert | (ctl.promote & ~seen_in);

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			valid_q <= ctl.insert ? ins_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			key_q   <= prev_entry.key;
			value_q <= prev_entry.value;
		end
	end

endmodule

@@ verif/lru_key_value_cache_test.sv @@
`timescale 1ns / 1ps

module lru_key_value_cache_test;

	import lkv_pkg::*;

	localparam int TABLE_SIZE = MAX_ENTRIES_DEF;
	// cycles with no request, config write or result before the run is called hung
	localparam int STALL_LIMIT = 2000;
	// spare cycles run after the last result has been checked
	localparam int TAIL_CYCLES = 6;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic {REQ_ITEM, CFG_ITEM} item_kind_t;

	typedef struct {
		item_kind_t      kind;
		logic            mode;
		word_t           key;
		word_t           wval;
		logic [CAP_W-1:0] cap;
	} stim_item_t;

	typedef struct {
		word_t key;
		word_t value;
	} cached_pair_t;

	typedef struct {
		logic  found;
		word_t read_value;
	} lookup_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             mode = MODE_GET;
	word_t            key = '0;
	word_t            write_value = '0;
	logic             done;
	logic             found;
	word_t            read_value;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	lru_key_value_cache i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key         (key),
		.write_value (write_value),
		.done        (done),
		.found       (found),
		.read_value  (read_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: entries ordered by recency, index 0 most recent.
	// ------------------------------------------------------------------
	cached_pair_t     lru_order[$];
	logic [CAP_W-1:0] cur_capacity = CAP_RESET;
	lookup_result_t   results_due[$];
	stim_item_t       pending[$];
	int               error_count = 0;

	// set at each rising edge: did the request / config write get taken
	logic acc_req = 1'b0;
	logic acc_cfg = 1'b0;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// One get or put against the recency list; returns the expected result.
	task automatic lru_access(input logic op, input word_t k, input word_t wv,
			output lookup_result_t res);
		int           pos;
		int           eff_cap;
		cached_pair_t p;
		pos = -1;
		for (int i = 0; i < lru_order.size(); i++) begin
			if (lru_order[i].key == k) begin
				pos = i;
				break;
			end
		end
		// capacity above the table size behaves as the table size
		eff_cap = (int'(cur_capacity) > TABLE_SIZE) ? TABLE_SIZE : int'(cur_capacity);
		if (pos >= 0) begin
			// hit: move to the head, update on put
			p = lru_order[pos];
			lru_order.delete(pos);
			res.found = 1'b1;
			if (op == MODE_PUT) begin
				p.value = wv;
				res.read_value = '0;
			end else begin
				res.read_value = p.value;
			end
			lru_order.push_front(p);
		end else begin
			res.found = 1'b0;
			if (op == MODE_GET) begin
				res.read_value = MISS_VALUE;
			end else begin
				res.read_value = '0;
				// zero capacity stores nothing; if the count is at or over
				// the capacity, only the single oldest entry is dropped
				if (eff_cap != 0) begin
					if (lru_order.size() >= eff_cap)
						void'(lru_order.pop_back());
					p.key = k;
					p.value = wv;
					lru_order.push_front(p);
				end
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Driver: changes inputs on the falling edge. The head of the pending
	// queue is held until taken; config writes wait for an empty pipe.
	// ------------------------------------------------------------------
	int gap_left = 0;
	int no_gap_left = 0;

	always @(negedge clk) begin : drive_requests
		logic             n_start;
		logic             n_cfg;
		logic             n_mode;
		word_t            n_key;
		word_t            n_wval;
		logic [CAP_W-1:0] n_cap;
		stim_item_t       head;
		n_start = 1'b0;
		n_cfg = 1'b0;
		// idle cycles carry junk on the data ports
		n_mode = 1'($urandom);
		n_key = word_t'($urandom);
		n_wval = word_t'($urandom);
		n_cap = CAP_W'($urandom);
		if (arst_n) begin
			if ((acc_req || acc_cfg) && pending.size() != 0) begin
				void'(pending.pop_front());
				if (no_gap_left > 0) begin
					no_gap_left--;
					gap_left = 0;
				end else begin
					gap_left = pick_gap();
					// now and then a back-to-back stretch
					if ($urandom_range(0, 49) == 0)
						no_gap_left = $urandom_range(20, 80);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() != 0) begin
				head = pending[0];
				if (head.kind == REQ_ITEM) begin
					n_start = 1'b1;
					n_mode = head.mode;
					n_key = head.key;
					n_wval = head.wval;
				end else if (results_due.size() == 0) begin
					// nothing in flight: safe to change capacity
					n_cfg = 1'b1;
					n_cap = head.cap;
				end
			end
		end
		start <= n_start;
		mode <= n_mode;
		key <= n_key;
		write_value <= n_wval;
		cfg_valid <= n_cfg;
		cfg_data <= n_cap;
	end

	// ------------------------------------------------------------------
	// Monitor: samples on the rising edge. Results are checked before the
	// request taken at the same edge is queued.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		lookup_result_t want;
		lookup_result_t got;
		if (arst_n) begin
			acc_req <= start && !busy;
			acc_cfg <= cfg_valid && cfg_ready;
			if (done) begin
				if (results_due.size() == 0) begin
					flag_error($sformatf("result with nothing outstanding: found=%0b value=%0d",
						found, read_value));
				end else begin
					want = results_due.pop_front();
					if (found !== want.found)
						flag_error($sformatf("found got %0b want %0b", found, want.found));
					if (read_value !== want.read_value)
						flag_error($sformatf("read_value got %0d want %0d",
							read_value, want.read_value));
				end
			end
			if (start && !busy) begin
				lru_access(mode, key, write_value, got);
				results_due.push_back(got);
			end
			if (cfg_valid && cfg_ready)
				cur_capacity = cfg_data;
		end
	end

	// Watchdog on cycles with no progress at all.
	int stalled_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready) || done)
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_request(input logic op, input word_t k, input word_t wv);
		stim_item_t it;
		it.kind = REQ_ITEM;
		it.mode = op;
		it.key = k;
		it.wval = wv;
		it.cap = '0;
		pending.push_back(it);
	endtask

	task automatic add_capacity(input logic [CAP_W-1:0] c);
		stim_item_t it;
		it.kind = CFG_ITEM;
		it.mode = MODE_GET;
		it.key = '0;
		it.wval = '0;
		it.cap = c;
		pending.push_back(it);
	endtask

	function automatic word_t edge_word();
		case ($urandom_range(0, 3))
			0: return word_t'(32'h8000_0000);
			1: return word_t'(32'h7fff_ffff);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	initial begin : stimulus
		localparam word_t W_MIN = word_t'(32'h8000_0000);
		localparam word_t W_MAX = word_t'(32'h7fff_ffff);
		word_t            key_pool[32];
		int               pool_n;
		int               old_n;
		int               eff;
		int               put_pct;
		word_t            k;
		word_t            wv;
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] first_caps[6];

		first_caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd2};

		// directed: empty miss, key/value extremes, hit on -1 vs miss value
		add_request(MODE_GET, '0, word_t'($urandom));
		add_request(MODE_PUT, W_MIN, W_MAX);
		add_request(MODE_PUT, W_MAX, W_MIN);
		add_request(MODE_PUT, '0, '0);
		add_request(MODE_PUT, '1, '1);
		add_request(MODE_GET, W_MIN, word_t'($urandom));
		add_request(MODE_GET, W_MAX, word_t'($urandom));
		add_request(MODE_GET, '0, word_t'($urandom));
		add_request(MODE_GET, '1, word_t'($urandom));
		add_request(MODE_PUT, W_MIN, word_t'(32'h1234_5678));
		add_request(MODE_GET, W_MIN, '0);
		add_request(MODE_GET, word_t'(5), '0);
		// capacity dropped below the held count: entries stay, one evicted per insert
		add_capacity(5'd2);
		add_request(MODE_PUT, word_t'(100), word_t'(1));
		add_request(MODE_PUT, word_t'(101), word_t'(2));
		add_request(MODE_GET, W_MIN, '0);
		add_request(MODE_GET, '1, '0);
		add_request(MODE_GET, word_t'(100), '0);
		add_request(MODE_GET, word_t'(101), '0);
		// zero capacity: new keys dropped, present keys still served
		add_capacity(5'd0);
		add_request(MODE_PUT, word_t'(77), word_t'(3));
		add_request(MODE_GET, word_t'(77), '0);
		add_request(MODE_PUT, word_t'(100), word_t'(4));
		add_request(MODE_GET, word_t'(100), '0);
		add_request(MODE_GET, word_t'(101), '0);

		// random phases, each at its own capacity; keys mostly from a small
		// pool so hits, updates and evictions all happen
		pool_n = 0;
		for (int ph = 0; ph < 16; ph++) begin
			cap = (ph < 6) ? first_caps[ph] : CAP_W'($urandom_range(0, 31));
			add_capacity(cap);
			eff = (int'(cap) > TABLE_SIZE) ? TABLE_SIZE : int'(cap);
			old_n = pool_n;
			pool_n = eff + $urandom_range(1, 8);
			if (pool_n > 32)
				pool_n = 32;
			for (int j = 0; j < pool_n; j++) begin
				// keep part of the old pool so held entries get hit again
				if (!(j < old_n && $urandom_range(0, 1) == 1)) begin
					if ($urandom_range(0, 7) == 0)
						key_pool[j] = edge_word();
					else
						key_pool[j] = word_t'($urandom);
				end
			end
			put_pct = $urandom_range(30, 70);
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 99) < 88)
					k = key_pool[$urandom_range(0, pool_n - 1)];
				else
					k = word_t'($urandom);
				wv = ($urandom_range(0, 9) == 0) ? edge_word() : word_t'($urandom);
				add_request(($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_GET, k, wv);
			end
		end

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
